// File: rtl/core/fsf_pkg.sv
// Shared types and constants of the floor surface finder.
`timescale 1ns / 1ps
package fsf_pkg;

	// Word select codes of a load word.
	localparam logic [3:0] SEL_NRM_X = 4'd10;
	localparam logic [3:0] SEL_OFS   = 4'd13;

	// Register indexes of the configuration port.
	localparam logic CFG_STATIC = 1'b0;
	localparam logic CFG_OBJECT = 1'b1;

	// Coordinate fields, in word select order.
	localparam int CRD_N    = 10;
	localparam int CRD_AX   = 0;
	localparam int CRD_AZ   = 1;
	localparam int CRD_BX   = 2;
	localparam int CRD_BZ   = 3;
	localparam int CRD_CX   = 4;
	localparam int CRD_CZ   = 5;
	localparam int CRD_MINX = 6;
	localparam int CRD_MAXX = 7;
	localparam int CRD_MINZ = 8;
	localparam int CRD_MAXZ = 9;
	localparam int NRM_N    = 3;

	// Plane numerator, shifted dividend and quotient widths.
	localparam int NUMW = 35;
	localparam int DVW  = 50;
	localparam int QW   = 51;

	localparam logic signed [16:0] CEIL_REACH = 17'sd78;
	localparam logic signed [31:0] H_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] H_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic write;
		logic capture;
		logic scan_start;
		logic issue;
		logic flush;
		logic div_start;
		logic load_hit;
		logic load_miss;
	} cmd_t;

	typedef struct packed {
		logic cand;
		logic scan_end;
		logic pipe_empty;
		logic div_done;
		logic height_ok;
	} status_t;

endpackage

// File: rtl/core/fsf_div.sv
// Restoring divider for the plane height, one quotient bit per cycle.
`timescale 1ns / 1ps
module fsf_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [34:0]     num,
	input  logic signed [17:0]     ny,
	output logic                   done,
	output logic signed [50:0]     quo
);
	import fsf_pkg::*;

	logic [DVW-1:0] q_q;
	logic [17:0]    rem_q;
	logic [17:0]    dsr_q;
	logic           neg_q;
	logic [5:0]     cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [NUMW-1:0] num_abs;
	logic [17:0]    ny_abs;
	logic [18:0]    sh;
	logic [18:0]    diff;

	assign num_abs = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
	assign ny_abs  = ny[17] ? 18'(-ny) : 18'(ny);
	assign sh      = {rem_q, q_q[DVW-1]};
	assign diff    = sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(DVW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= {num_abs[33:0], 16'b0};
			rem_q <= '0;
			dsr_q <= ny_abs;
			// The height is -num / ny, so it is negative when both signs agree.
			neg_q <= (num[NUMW-1] == ny[17]);
		end else if (busy_q) begin
			if (!diff[18]) begin
				rem_q <= diff[17:0];
				q_q   <= {q_q[DVW-2:0], 1'b1};
			end else begin
				rem_q <= sh[17:0];
				q_q   <= {q_q[DVW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
endmodule

// File: rtl/core/fsf_dp.sv
// Datapath: surface table memories, scan pipeline, height check and result word.
`timescale 1ns / 1ps
module fsf_dp #(
	parameter int MAX_SURFACES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [8:0]           cfg_data,
	input  logic [7:0]           entry_index,
	input  logic [3:0]           word_select,
	input  logic signed [32:0]   word_value,
	input  logic signed [15:0]   pos_x,
	input  logic signed [15:0]   pos_y,
	input  logic signed [15:0]   pos_z,
	input  logic                 use_objects,
	input  fsf_pkg::cmd_t        cmd,
	output fsf_pkg::status_t     st,
	output logic                 found,
	output logic [7:0]           floor_index,
	output logic signed [31:0]   floor_height
);
	import fsf_pkg::*;

	localparam int IW   = $clog2(MAX_SURFACES);
	localparam int BW   = ($clog2(MAX_SURFACES + 1) > 9) ? $clog2(MAX_SURFACES + 1) : 9;
	localparam int CNTW = BW + 1;
	localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_SURFACES);

	logic [8:0]      static_count_q;
	logic [8:0]      object_count_q;
	logic [CNTW-1:0] ptr_q;
	logic [CNTW-1:0] end_q;
	logic [CNTW-1:0] sc;
	logic [CNTW-1:0] tot;
	logic [CNTW-1:0] tot_c;
	logic [CNTW-1:0] wr_idx;
	logic [IW-1:0]   wr_addr;
	logic [IW-1:0]   rd_addr;
	logic            wr_en;
	logic            iss;

	logic signed [15:0] pos_x_q, pos_y_q, pos_z_q;

	logic signed [15:0] crd_s1 [CRD_N];
	logic signed [17:0] nrm_s1 [NRM_N];
	logic signed [32:0] ofs_s1;
	logic               v_s1;
	logic [CNTW-1:0]    idx_s1;

	logic signed [16:0] dif_s2 [12];
	logic signed [17:0] nrm_s2 [NRM_N];
	logic signed [32:0] ofs_s2;
	logic               box_s2;
	logic               v_s2;
	logic [CNTW-1:0]    idx_s2;

	logic signed [33:0] prd_s3 [6];
	logic signed [33:0] pxn_s3, pzn_s3;
	logic signed [17:0] ny_s3;
	logic signed [32:0] ofs_s3;
	logic               box_s3;
	logic               v_s3;
	logic [CNTW-1:0]    idx_s3;

	logic signed [34:0] num_s4;
	logic signed [17:0] ny_s4;
	logic               v_s4;
	logic               pass_s4;
	logic [CNTW-1:0]    idx_s4;

	logic signed [34:0] edg [3];
	logic               edges_ok;
	logic               box_ok;
	logic [CNTW-1:0]    idx_hit_q;
	logic               div_done;
	logic signed [50:0] quo;
	logic signed [32:0] lim;
	logic signed [31:0] h_sat;
	logic signed [16:0] y_reach;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			static_count_q <= '0;
			object_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STATIC: static_count_q <= cfg_data;
				CFG_OBJECT: object_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign wr_idx  = CNTW'(entry_index);
	assign wr_addr = wr_idx[IW-1:0];
	assign wr_en   = cmd.write && (wr_idx < MAXC);
	assign rd_addr = ptr_q[IW-1:0];
	assign iss     = cmd.issue && (ptr_q < end_q);

	for (genvar g = 0; g < CRD_N; g++) begin : g_crd
		logic [15:0] mem [MAX_SURFACES];
		always_ff @(posedge clk) begin
			if (wr_en && word_select == 4'(g))
				mem[wr_addr] <= word_value[15:0];
			if (iss)
				crd_s1[g] <= $signed(mem[rd_addr]);
		end
	end

	for (genvar g = 0; g < NRM_N; g++) begin : g_nrm
		logic [17:0] mem [MAX_SURFACES];
		always_ff @(posedge clk) begin
			if (wr_en && word_select == SEL_NRM_X + 4'(g))
				mem[wr_addr] <= word_value[17:0];
			if (iss)
				nrm_s1[g] <= $signed(mem[rd_addr]);
		end
	end

	logic [32:0] ofs_mem [MAX_SURFACES];
	always_ff @(posedge clk) begin
		if (wr_en && word_select == SEL_OFS)
			ofs_mem[wr_addr] <= word_value;
		if (iss)
			ofs_s1 <= $signed(ofs_mem[rd_addr]);
	end

	// Region bounds, with both regions cut off at the table size.
	always_comb begin
		sc    = (CNTW'(static_count_q) > MAXC) ? MAXC : CNTW'(static_count_q);
		tot   = sc + CNTW'(object_count_q);
		tot_c = (tot > MAXC) ? MAXC : tot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			end_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			pass_s4 <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				ptr_q <= use_objects ? sc : '0;
				end_q <= use_objects ? tot_c : sc;
			end else if (cmd.flush) begin
				ptr_q <= idx_s4 + CNTW'(1);
			end else if (iss) begin
				ptr_q <= ptr_q + CNTW'(1);
			end
			if (cmd.flush) begin
				v_s1    <= 1'b0;
				v_s2    <= 1'b0;
				v_s3    <= 1'b0;
				v_s4    <= 1'b0;
				pass_s4 <= 1'b0;
			end else begin
				v_s1    <= iss;
				v_s2    <= v_s1;
				v_s3    <= v_s2;
				v_s4    <= v_s3;
				pass_s4 <= v_s3 && box_s3 && edges_ok && (ny_s3 != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			pos_z_q <= pos_z;
		end
	end

	assign box_ok = !(pos_x_q < crd_s1[CRD_MINX] || pos_x_q > crd_s1[CRD_MAXX] ||
		pos_z_q < crd_s1[CRD_MINZ] || pos_z_q > crd_s1[CRD_MAXZ]);

	always_comb begin
		for (int k = 0; k < 3; k++)
			edg[k] = 35'(prd_s3[2*k]) - 35'(prd_s3[2*k+1]);
		edges_ok = !edg[0][34] && !edg[1][34] && !edg[2][34];
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;

		// Edge differences, four per edge: (az-z),(bx-ax),(ax-x),(bz-az) and rotations.
		dif_s2[0]  <= 17'(crd_s1[CRD_AZ]) - 17'(pos_z_q);
		dif_s2[1]  <= 17'(crd_s1[CRD_BX]) - 17'(crd_s1[CRD_AX]);
		dif_s2[2]  <= 17'(crd_s1[CRD_AX]) - 17'(pos_x_q);
		dif_s2[3]  <= 17'(crd_s1[CRD_BZ]) - 17'(crd_s1[CRD_AZ]);
		dif_s2[4]  <= 17'(crd_s1[CRD_BZ]) - 17'(pos_z_q);
		dif_s2[5]  <= 17'(crd_s1[CRD_CX]) - 17'(crd_s1[CRD_BX]);
		dif_s2[6]  <= 17'(crd_s1[CRD_BX]) - 17'(pos_x_q);
		dif_s2[7]  <= 17'(crd_s1[CRD_CZ]) - 17'(crd_s1[CRD_BZ]);
		dif_s2[8]  <= 17'(crd_s1[CRD_CZ]) - 17'(pos_z_q);
		dif_s2[9]  <= 17'(crd_s1[CRD_AX]) - 17'(crd_s1[CRD_CX]);
		dif_s2[10] <= 17'(crd_s1[CRD_CX]) - 17'(pos_x_q);
		dif_s2[11] <= 17'(crd_s1[CRD_AZ]) - 17'(crd_s1[CRD_CZ]);
		for (int k = 0; k < NRM_N; k++)
			nrm_s2[k] <= nrm_s1[k];
		ofs_s2 <= ofs_s1;
		box_s2 <= box_ok;
		idx_s2 <= idx_s1;

		for (int k = 0; k < 6; k++)
			prd_s3[k] <= 34'(dif_s2[2*k]) * 34'(dif_s2[2*k+1]);
		pxn_s3 <= 34'(pos_x_q) * 34'(nrm_s2[0]);
		pzn_s3 <= 34'(pos_z_q) * 34'(nrm_s2[2]);
		ny_s3  <= nrm_s2[1];
		ofs_s3 <= ofs_s2;
		box_s3 <= box_s2;
		idx_s3 <= idx_s2;

		num_s4 <= 35'(pxn_s3) + 35'(pzn_s3) + 35'(ofs_s3);
		ny_s4  <= ny_s3;
		idx_s4 <= idx_s3;

		if (cmd.div_start)
			idx_hit_q <= idx_s4;
	end

	fsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_s4),
		.ny     (ny_s4),
		.done   (div_done),
		.quo    (quo)
	);

	assign y_reach = 17'(pos_y_q) + CEIL_REACH;
	assign lim     = $signed({y_reach, 16'b0});

	always_comb begin
		if (quo > 51'(H_MAX))
			h_sat = H_MAX;
		else if (quo < 51'(H_MIN))
			h_sat = H_MIN;
		else
			h_sat = quo[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hit) begin
			found        <= 1'b1;
			floor_index  <= idx_hit_q[7:0];
			floor_height <= h_sat;
		end else if (cmd.load_miss) begin
			found        <= 1'b0;
			floor_index  <= '0;
			floor_height <= '0;
		end
	end

	assign st.cand       = pass_s4;
	assign st.scan_end   = (ptr_q >= end_q);
	assign st.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign st.div_done   = div_done;
	assign st.height_ok  = (quo <= 51'(lim));
endmodule

// File: rtl/core/fsf_ctrl.sv
// Controller: input and output handshakes and the scan and divide sequence.
`timescale 1ns / 1ps
module fsf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              func,
	input  logic              out_ready,
	input  fsf_pkg::status_t  st,
	output logic              in_ready,
	output logic              out_valid,
	output fsf_pkg::cmd_t     cmd
);
	import fsf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !func)
					cmd.write = 1'b1;
				if (in_valid && func) begin
					cmd.capture    = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// A candidate at the end of the pipeline stops the scan; later entries
				// in flight are dropped and fetched again if the height test fails.
				if (st.cand) begin
					cmd.flush     = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.issue = 1'b1;
					if (st.scan_end && st.pipe_empty && out_free) begin
						cmd.load_miss = 1'b1;
						state_d       = ST_IDLE;
					end
				end
			end
			ST_DIV: begin
				if (st.div_done) begin
					if (!st.height_ok) begin
						state_d = ST_SCAN;
					end else if (out_free) begin
						cmd.load_hit = 1'b1;
						state_d      = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_hit || cmd.load_miss)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

// File: rtl/core/floor_surface_finder_unit.sv
// Top level of the floor surface finder: controller, datapath and ports.
//
//  channel | handshake            | word
//  in      | in_valid / in_ready  | func, entry_index, word_select, word_value, pos_*, use_objects
//  out     | out_valid / out_ready| found, floor_index, floor_height
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// A load word leaves the unit idle. A query scans the entries of its region in order;
// every entry that passes the box, edge and nonzero normal y tests adds a run of the
// one-bit-per-cycle divider and a refetch of the entries dropped behind it.
// Reset clears the controller and counts; the table is undefined until written.
// A waiting result does not stop load words; a finished query waits for the output.
`timescale 1ns / 1ps
module floor_surface_finder_unit #(
	parameter int MAX_SURFACES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [7:0]          entry_index,
	input  logic [3:0]          word_select,
	input  logic signed [32:0]  word_value,
	input  logic signed [15:0]  pos_x,
	input  logic signed [15:0]  pos_y,
	input  logic signed [15:0]  pos_z,
	input  logic                use_objects,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                found,
	output logic [7:0]          floor_index,
	output logic signed [31:0]  floor_height,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [8:0]          cfg_data
);
	import fsf_pkg::*;

	cmd_t    cmd;
	status_t st;

	fsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.out_ready (out_ready),
		.st        (st),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	fsf_dp #(.MAX_SURFACES(MAX_SURFACES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.entry_index  (entry_index),
		.word_select  (word_select),
		.word_value   (word_value),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.use_objects  (use_objects),
		.cmd          (cmd),
		.st           (st),
		.found        (found),
		.floor_index  (floor_index),
		.floor_height (floor_height)
	);
endmodule

// File: rtl/core/fsf_chk.sv
// Port checker for the floor surface finder, bound to the top level.
`timescale 1ns / 1ps
module fsf_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                func,
	input logic                out_valid,
	input logic                out_ready,
	input logic                found,
	input logic [7:0]          floor_index,
	input logic signed [31:0]  floor_height
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) &&
		$stable(floor_index) && $stable(floor_height))
		else $error("result word changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> floor_index == 8'd0 && floor_height == 32'sd0)
		else $error("miss result carries a nonzero index or height");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func |=> !in_ready)
		else $error("input ready right after a query word");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result word appeared without a query in progress");
endmodule

bind floor_surface_finder_unit fsf_chk u_chk (.*);

// File: tb/tb_top.sv
// Self-checking testbench of the floor surface finder: stimulus, predictor and scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import fsf_pkg::*;

	// Entries filled by the testbench; the counts of the random phases keep their scans inside them.
	localparam int N_FILL = 24;

	typedef struct {
		bit                  hit;
		logic [7:0]          idx;
		logic signed [31:0]  height;
	} floor_answer_t;

	// Scoreboard: keeps its own copy of the surface table and counts, and
	// predicts the answer of every accepted query word.
	class floor_scoreboard;
		logic signed [15:0] crd [256][CRD_N];
		logic signed [17:0] nrm [256][NRM_N];
		logic signed [32:0] ofs [256];
		int unsigned n_static, n_object;
		floor_answer_t answer_q[$];
		int errors, queries, hits, loads;

		function void set_count(logic idx, logic [8:0] v);
			if (idx == CFG_STATIC)
				n_static = v;
			else
				n_object = v;
		endfunction

		function bit floor_under(int i, longint x, longint y, longint z, output longint h);
			longint ax, az, bx, bz, cx, cz, nx, ny, nz, num;
			h = 0;
			if (x < longint'(crd[i][CRD_MINX]) || x > longint'(crd[i][CRD_MAXX]) ||
			    z < longint'(crd[i][CRD_MINZ]) || z > longint'(crd[i][CRD_MAXZ]))
				return 0;
			ax = crd[i][CRD_AX]; az = crd[i][CRD_AZ];
			bx = crd[i][CRD_BX]; bz = crd[i][CRD_BZ];
			cx = crd[i][CRD_CX]; cz = crd[i][CRD_CZ];
			if ((az - z) * (bx - ax) - (ax - x) * (bz - az) < 0) return 0;
			if ((bz - z) * (cx - bx) - (bx - x) * (cz - bz) < 0) return 0;
			if ((cz - z) * (ax - cx) - (cx - x) * (az - cz) < 0) return 0;
			nx = nrm[i][0]; ny = nrm[i][1]; nz = nrm[i][2];
			if (ny == 0) return 0;
			num = x * nx + z * nz + longint'(ofs[i]);
			h = (-num * 65536) / ny;
			if (h > (y + 78) * 65536) return 0;
			return 1;
		endfunction

		function void note_word(logic fn, logic [7:0] idx, logic [3:0] sel,
		                        logic signed [32:0] val, logic signed [15:0] px,
		                        logic signed [15:0] py, logic signed [15:0] pz, logic uo);
			floor_answer_t a;
			int unsigned sc, lo, hi;
			longint h;
			if (!fn) begin
				loads++;
				if (sel < SEL_NRM_X)
					crd[idx][sel] = val[15:0];
				else if (sel < SEL_OFS)
					nrm[idx][sel - SEL_NRM_X] = val[17:0];
				else if (sel == SEL_OFS)
					ofs[idx] = val;
				return;
			end
			queries++;
			sc = (n_static > 256) ? 256 : n_static;
			lo = uo ? sc : 0;
			hi = uo ? ((sc + n_object > 256) ? 256 : sc + n_object) : sc;
			a.hit = 0; a.idx = 0; a.height = 0;
			for (int i = lo; i < hi; i++) begin
				if (floor_under(i, px, py, pz, h)) begin
					if (h > 64'sd2147483647) h = 64'sd2147483647;
					if (h < -64'sd2147483648) h = -64'sd2147483648;
					a.hit = 1; a.idx = i[7:0]; a.height = h[31:0];
					hits++;
					break;
				end
			end
			answer_q.push_back(a);
		endfunction

		function void check(logic f, logic [7:0] idx, logic signed [31:0] h);
			floor_answer_t a;
			if (answer_q.size() == 0) begin
				$error("result word with no query waiting");
				errors++;
				return;
			end
			a = answer_q.pop_front();
			if (f !== a.hit) begin
				$error("found: expected %0d actual %0d", a.hit, f); errors++;
			end
			if (idx !== a.idx) begin
				$error("floor_index: expected %0d actual %0d", a.idx, idx); errors++;
			end
			if (h !== a.height) begin
				$error("floor_height: expected %0d actual %0d", a.height, h); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic [7:0] entry_index = '0;
	logic [3:0] word_select = '0;
	logic signed [32:0] word_value = '0;
	logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic use_objects = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [7:0] floor_index;
	logic signed [31:0] floor_height;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [8:0] cfg_data = '0;

	floor_scoreboard sb = new();
	bit calm;
	int stall_left;
	int cen_x [256], cen_z [256], h_design [256];
	int unsigned cur_static, cur_object;
	int unsigned rs;

	floor_surface_finder_unit DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic int clip16(int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			out_ready = 1'b1;
			stall_left = gap_len();
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check(found, floor_index, floor_height);

	task automatic send_word(logic fn, logic [7:0] idx, logic [3:0] sel,
	                         logic signed [32:0] val, logic signed [15:0] px,
	                         logic signed [15:0] py, logic signed [15:0] pz, logic uo);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		func = fn; entry_index = idx; word_select = sel; word_value = val;
		pos_x = px; pos_y = py; pos_z = pz; use_objects = uo;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_word(fn, idx, sel, val, px, py, pz, uo);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic load_word(int i, int sel, logic signed [32:0] val);
		send_word(1'b0, i[7:0], sel[3:0], val, 16'($urandom), 16'($urandom), 16'($urandom),
		          1'($urandom));
	endtask

	task automatic query(int x, int y, int z, logic uo);
		send_word(1'b1, 8'($urandom), 4'($urandom), 33'({$urandom, $urandom}),
		          16'(clip16(x)), 16'(clip16(y)), 16'(clip16(z)), uo);
	endtask

	// Writes all fourteen words of one entry in a shuffled order. The second
	// and third vertices are swapped when needed so the edge tests face inward.
	task automatic build_floor(int i, int x0, int z0, int x1, int z1, int x2, int z2,
	                           int nx, int ny, int nz, longint offs);
		int v [14];
		int order [$];
		int gx, gz, t;
		gx = (x0 + x1 + x2) / 3;
		gz = (z0 + z1 + z2) / 3;
		if (longint'(z0 - gz) * (x1 - x0) - longint'(x0 - gx) * (z1 - z0) < 0) begin
			t = x1; x1 = x2; x2 = t;
			t = z1; z1 = z2; z2 = t;
		end
		v[CRD_AX] = x0; v[CRD_AZ] = z0; v[CRD_BX] = x1;
		v[CRD_BZ] = z1; v[CRD_CX] = x2; v[CRD_CZ] = z2;
		v[CRD_MINX] = (x0 < x1) ? ((x0 < x2) ? x0 : x2) : ((x1 < x2) ? x1 : x2);
		v[CRD_MAXX] = (x0 > x1) ? ((x0 > x2) ? x0 : x2) : ((x1 > x2) ? x1 : x2);
		v[CRD_MINZ] = (z0 < z1) ? ((z0 < z2) ? z0 : z2) : ((z1 < z2) ? z1 : z2);
		v[CRD_MAXZ] = (z0 > z1) ? ((z0 > z2) ? z0 : z2) : ((z1 > z2) ? z1 : z2);
		v[SEL_NRM_X] = nx; v[SEL_NRM_X + 1] = ny; v[SEL_NRM_X + 2] = nz;
		for (int k = 0; k < 14; k++) order.push_back(k);
		order.shuffle();
		foreach (order[k]) begin
			if (order[k] == SEL_OFS)
				load_word(i, SEL_OFS, offs[32:0]);
			else
				load_word(i, order[k], 33'(signed'(v[order[k]])));
		end
		cen_x[i] = gx; cen_z[i] = gz;
	endtask

	task automatic random_floor(int i);
		int gx, gz, sp, nx, ny, nz, h0, r;
		gx = $urandom_range(0, 60000) - 30000;
		gz = $urandom_range(0, 60000) - 30000;
		sp = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 2000) : $urandom_range(1, 300);
		r = $urandom_range(0, 99);
		ny = (r < 5) ? 0 : ((r < 12) ? -$urandom_range(1, 131072) : $urandom_range(16000, 131071));
		nx = $urandom_range(0, 6000) - 3000;
		nz = $urandom_range(0, 6000) - 3000;
		h0 = $urandom_range(0, 40000) - 20000;
		h_design[i] = h0;
		build_floor(i, clip16(gx + $urandom_range(0, 2 * sp) - sp),
		            clip16(gz + $urandom_range(0, 2 * sp) - sp),
		            clip16(gx + $urandom_range(0, 2 * sp) - sp),
		            clip16(gz + $urandom_range(0, 2 * sp) - sp),
		            clip16(gx + $urandom_range(0, 2 * sp) - sp),
		            clip16(gz + $urandom_range(0, 2 * sp) - sp),
		            nx, ny, nz, -longint'(h0) * ny - longint'(gx) * nx - longint'(gz) * nz);
	endtask

	task automatic drain();
		do @(negedge clk); while (sb.answer_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_counts(int unsigned s, int unsigned o);
		drain();
		cfg_we = 1'b1; cfg_index = CFG_STATIC; cfg_data = s[8:0];
		@(negedge clk);
		sb.set_count(CFG_STATIC, s[8:0]);
		cfg_index = CFG_OBJECT; cfg_data = o[8:0];
		@(negedge clk);
		sb.set_count(CFG_OBJECT, o[8:0]);
		cfg_we = 1'b0;
		cur_static = s; cur_object = o;
	endtask

	// Mostly queries aimed at a floor of the searched region, plus rebuilt
	// entries, raw words, ignored selects and wild positions.
	task automatic random_phase(int n);
		int r, i, sc, lo, hi;
		bit uo;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			uo = 1'($urandom);
			sc = (cur_static > 256) ? 256 : cur_static;
			lo = uo ? sc : 0;
			hi = uo ? ((sc + cur_object > 256) ? 256 : sc + cur_object) : sc;
			i = (hi > lo) ? $urandom_range(lo, hi - 1) : $urandom_range(0, N_FILL - 1);
			if (r < 70)
				query(cen_x[i] + $urandom_range(0, 4) - 2, h_design[i] + $urandom_range(0, 160) - 120,
				      cen_z[i] + $urandom_range(0, 4) - 2, uo);
			else if (r < 78)
				query($urandom, $urandom, $urandom, uo);
			else if (r < 80)
				random_floor($urandom_range(0, N_FILL - 1));
			else if (r < 94)
				load_word($urandom_range(0, 255), $urandom_range(0, 13), 33'({$urandom, $urandom}));
			else
				load_word($urandom_range(0, 255), $urandom_range(14, 15),
				          33'({$urandom, $urandom}));
		end
	endtask

	initial begin
		calm = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Entry covering the whole extent with extreme normals, so heights saturate.
		build_floor(0, -32768, -32768, 32767, -32768, 0, 32767, 131071, 1, -131072,
		            64'sd4294967295);
		// Entry with zero normal y, never a floor.
		build_floor(1, -100, -100, 100, -100, 0, 100, 0, 0, 0, 0);
		h_design[0] = 0; h_design[1] = 0;
		for (int i = 2; i < N_FILL; i++) random_floor(i);

		set_counts(1, 2);
		query(-32768, -32768, -32768, 1'b0);
		query(32767, 32767, -32768, 1'b0);
		query(0, 0, 32767, 1'b0);
		query(-32768, 32767, 32767, 1'b0);
		query(0, 0, 0, 1'b1);
		query(cen_x[2], h_design[2], cen_z[2], 1'b1);
		query(cen_x[2], h_design[2] - 78, cen_z[2], 1'b1);
		query(cen_x[2], h_design[2] - 79, cen_z[2], 1'b1);
		query(cen_x[2], h_design[2] - 200, cen_z[2], 1'b1);
		load_word(3, 14, 33'h1_FFFF_FFFF);
		load_word(3, 15, 33'h1_0000_0000);
		set_counts(0, 0);
		query(0, 0, 0, 1'b0);
		query(0, 0, 0, 1'b1);
		// Oversized counts clamp to the table size. The object region is then
		// empty, and the static scan stops at the first entry, which covers the origin.
		set_counts(511, 511);
		query(0, 100, 0, 1'b0);
		query(cen_x[5], h_design[5], cen_z[5], 1'b1);
		set_counts(256, 0);
		query(0, -5000, 0, 1'b0);
		set_counts(0, 256);
		query(0, 0, 0, 1'b1);
		query(5, 5, 5, 1'b0);

		for (int p = 0; p < 12; p++) begin
			calm = (p % 4 == 3);
			rs = $urandom_range(0, N_FILL);
			case (p)
				0: set_counts(4, 4);
				1: set_counts(N_FILL, 0);
				2: set_counts(0, N_FILL);
				3: set_counts(N_FILL / 2, N_FILL - N_FILL / 2);
				default: set_counts(rs, $urandom_range(0, N_FILL - rs));
			endcase
			random_phase(25);
			if (p == 5) begin
				// Hold the sender back until every answer has come out.
				in_valid = 1'b0;
				do @(negedge clk); while (sb.answer_q.size() != 0);
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
			random_phase(25);
		end
		in_valid = 1'b0;
		calm = 1'b0;
		drain();
		repeat (100) @(negedge clk);
		$display("Ran %0d queries (%0d hits) and %0d load words over 17 count settings.",
		         sb.queries, sb.hits, sb.loads);
		if (sb.errors == 0 && sb.answer_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
